>>> hw/rtl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// Request and result structs, operation codes, cell control structs.
// No dependencies.
package tcpq_pkg;

  localparam int unsigned ENTRY_ID_W   = 12;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ID_BITS_DEF  = 12;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_DEPART = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    kind_e                 kind;
    logic [ENTRY_ID_W-1:0] entry_id;
    logic                  entry_class;
    logic                  urgent;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [COUNT_W-1:0] total_count;
    logic [COUNT_W-1:0] urgent_count;
  } out_item_t;

  // Broadcast to every cell; each enable is already qualified by the checks.
  typedef struct packed {
    logic ins_en;
    logic rm_en;
    logic dep_en;
  } cell_cmd_t;

  // Per-cell position info derived from the lengths.
  typedef struct packed {
    logic occ;        // cell holds a queued entry
    logic ins_here;   // new id lands in this cell
    logic ins_after;  // cell sits behind the insert point
    logic urg;        // cell is in the urgent section
  } cell_pos_t;

endpackage

>>> hw/rtl/tcpq_cell.sv
// One storage cell of the queue chain: holds one id, compares it with the key
// and shifts toward either neighbor. Depends on tcpq_pkg.
module tcpq_cell #(
  parameter int unsigned ID_BITS = tcpq_pkg::ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  tcpq_pkg::cell_cmd_t  cmd_i,
  input  tcpq_pkg::cell_pos_t  pos_i,
  input  logic [ID_BITS-1:0]   key_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic                 hit_i,
  output logic [ID_BITS-1:0]   id_o,
  output logic                 hit_o,
  output logic                 urg_hit_o
);
  import tcpq_pkg::*;

  logic [ID_BITS-1:0] id_q, id_d;
  logic               match;

  assign match     = pos_i.occ && (id_q == key_i);
  // prefix OR: set from the matching cell to the tail
  assign hit_o     = hit_i | match;
  assign urg_hit_o = match & pos_i.urg;
  assign id_o      = id_q;

  always_comb begin
    id_d = id_q;
    if (cmd_i.dep_en || (cmd_i.rm_en && hit_o)) begin
      id_d = right_id_i;
    end else if (cmd_i.ins_en) begin
      if (pos_i.ins_here) begin
        id_d = key_i;
      end else if (pos_i.ins_after) begin
        id_d = left_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

>>> hw/rtl/two_class_priority_queue.sv
// Two-class priority queue of unique nonzero ids: urgent entries first, normal
// ones after, each in arrival order. Requests are add, remove by id, depart head
// and lookup; every request gives one result with status, found flag and both
// counts after the step. One request is taken per clock: all cells compare the
// key and shift in the same cycle, and the result sits in the output register
// in the cycle after acceptance. Requests stall only while that register holds
// a result that is not taken. No clearing pass after reset.
// Depends on tcpq_pkg and tcpq_cell.
module two_class_priority_queue #(
  parameter int unsigned CAPACITY = tcpq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = tcpq_pkg::ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcpq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcpq_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import tcpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             acc_class_q;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] ulen_q, ulen_d;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic                      accept;
  logic [ID_BITS+ENTRY_ID_W-1:0] id_ext;
  logic [ID_BITS-1:0]        key;
  logic                      key_ok;
  logic [CNT_W-1:0]          ins_pos;
  cell_cmd_t                 cmd;
  logic                      ok, found;
  logic                      any_hit, urg_hit;

  logic [ID_BITS-1:0] id_vec [CAPACITY];
  logic [CAPACITY:0]  hit_vec;
  logic [CAPACITY-1:0] urg_vec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  assign id_ext  = {ID_BITS'(0), in_data_i.entry_id};
  assign key     = id_ext[ID_BITS-1:0];
  assign key_ok  = (key != '0);
  assign ins_pos = in_data_i.urgent ? ulen_q : len_q;

  assign hit_vec[0] = 1'b0;
  assign any_hit    = hit_vec[CAPACITY];
  assign urg_hit    = |urg_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    cell_pos_t          pos;
    logic [ID_BITS-1:0] left_id, right_id;

    assign pos.occ       = (IDX < len_q);
    assign pos.ins_here  = (IDX == ins_pos);
    assign pos.ins_after = (IDX > ins_pos);
    assign pos.urg       = (IDX < ulen_q);

    if (i == 0) begin : g_head
      assign left_id = key;
    end else begin : g_body
      assign left_id = id_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_id = id_vec[i];
    end else begin : g_inner
      assign right_id = id_vec[i+1];
    end

    tcpq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .pos_i     (pos),
      .key_i     (key),
      .left_id_i (left_id),
      .right_id_i(right_id),
      .hit_i     (hit_vec[i]),
      .id_o      (id_vec[i]),
      .hit_o     (hit_vec[i+1]),
      .urg_hit_o (urg_vec[i])
    );
  end

  always_comb begin
    ok    = 1'b0;
    found = 1'b0;
    unique case (in_data_i.kind)
      KIND_ADD: begin
        ok = (in_data_i.entry_class == acc_class_q) && key_ok &&
             (len_q != CNT_W'(CAPACITY)) && !any_hit;
      end
      KIND_REMOVE: ok = key_ok && any_hit;
      KIND_DEPART: ok = (len_q != '0);
      KIND_LOOKUP: begin
        ok    = 1'b1;
        found = key_ok && any_hit;
      end
      default: begin
        ok    = 1'b0;
        found = 1'b0;
      end
    endcase
  end

  assign cmd.ins_en = accept && ok && (in_data_i.kind == KIND_ADD);
  assign cmd.rm_en  = accept && ok && (in_data_i.kind == KIND_REMOVE);
  assign cmd.dep_en = accept && ok && (in_data_i.kind == KIND_DEPART);

  always_comb begin
    len_d  = len_q;
    ulen_d = ulen_q;
    if (cmd.ins_en) begin
      len_d = len_q + CNT_W'(1);
      if (in_data_i.urgent) begin
        ulen_d = ulen_q + CNT_W'(1);
      end
    end else if (cmd.rm_en) begin
      len_d = len_q - CNT_W'(1);
      if (urg_hit) begin
        ulen_d = ulen_q - CNT_W'(1);
      end
    end else if (cmd.dep_en) begin
      len_d = len_q - CNT_W'(1);
      // head is urgent whenever the urgent section is not empty
      if (ulen_q != '0) begin
        ulen_d = ulen_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_class_q <= 1'b0;
      len_q       <= '0;
      ulen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        acc_class_q <= cfg_data_i;
      end
      len_q  <= len_d;
      ulen_q <= ulen_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.status       <= ok ? STATUS_OK : STATUS_FAIL;
      out_data_q.found        <= found;
      out_data_q.total_count  <= COUNT_W'(len_d);
      out_data_q.urgent_count <= COUNT_W'(ulen_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/tcpq_checker.sv
// Port-level checker for the two-class priority queue, bound to the top level.
// Depends on tcpq_pkg.
module tcpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tcpq_pkg::out_item_t out_data_o
);
  import tcpq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // every accepted request yields a result in the next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // requests stall only behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled with free output");

  // found only comes from a lookup, which always succeeds
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == STATUS_OK)
    else $error("found set on failed result");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

>>> tb/two_class_priority_queue_test.sv
// Self-checking bench for two_class_priority_queue: directed edge cases, then
// random add/remove/depart/lookup traffic under both accepted-class settings.
// Depends on tcpq_pkg and the two_class_priority_queue RTL.
module two_class_priority_queue_test;
  import tcpq_pkg::*;

  localparam int unsigned CAPACITY   = CAPACITY_DEF;
  localparam int          CYCLE_LIMIT = 300000;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;

  two_class_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the queue contents and the class register
  logic [ENTRY_ID_W-1:0] queued_model [CAPACITY];
  int                    queued_len  = 0;
  int                    urgent_len  = 0;
  logic                  class_model = 1'b0;

  out_item_t pending_results [$];

  int mismatch_count  = 0;
  int requests_sent   = 0;
  int requests_failed = 0;
  int results_checked = 0;
  int full_hits       = 0;
  int class_writes    = 0;
  int cycle_count     = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int find_entry(logic [ENTRY_ID_W-1:0] id);
    int i;
    for (i = 0; i < queued_len; i++) begin
      if (queued_model[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < queued_len; i++) queued_model[i] = queued_model[i + 1];
    queued_len--;
    if (pos < urgent_len) urgent_len--;
  endfunction

  // Advances the shadow queue by one request and returns the result it gives
  function automatic out_item_t queue_step_result(in_item_t req);
    out_item_t res;
    int        pos;
    int        i;
    res        = '0;
    res.status = STATUS_FAIL;
    case (req.kind)
      KIND_ADD: begin
        if (req.entry_class == class_model && req.entry_id != '0 &&
            queued_len < CAPACITY && find_entry(req.entry_id) < 0) begin
          pos = req.urgent ? urgent_len : queued_len;
          for (i = queued_len; i > pos; i--) queued_model[i] = queued_model[i - 1];
          queued_model[pos] = req.entry_id;
          queued_len++;
          if (req.urgent) urgent_len++;
          res.status = STATUS_OK;
        end
      end
      KIND_REMOVE: begin
        pos = (req.entry_id != '0) ? find_entry(req.entry_id) : -1;
        if (pos >= 0) begin
          drop_entry(pos);
          res.status = STATUS_OK;
        end
      end
      KIND_DEPART: begin
        if (queued_len > 0) begin
          drop_entry(0);
          res.status = STATUS_OK;
        end
      end
      default: begin
        res.found  = (req.entry_id != '0) && (find_entry(req.entry_id) >= 0);
        res.status = STATUS_OK;
      end
    endcase
    res.total_count  = COUNT_W'(queued_len);
    res.urgent_count = COUNT_W'(urgent_len);
    return res;
  endfunction

  function automatic in_item_t make_request(kind_e k, logic [ENTRY_ID_W-1:0] id,
                                            logic cls, logic urg);
    in_item_t req;
    req.kind        = k;
    req.entry_id    = id;
    req.entry_class = cls;
    req.urgent      = urg;
    return req;
  endfunction

  // Mostly small ids so duplicates and hits are common; weights lean toward
  // adds while the queue is short and toward removal once it is nearly full.
  function automatic in_item_t random_request();
    in_item_t req;
    int       roll;
    int       add_w;
    kind_e    k;
    logic [ENTRY_ID_W-1:0] id;
    add_w = (queued_len < 6) ? 55 : (queued_len >= 14) ? 30 : 42;
    roll  = $urandom_range(0, 99);
    if (roll < add_w)                          k = KIND_ADD;
    else if (roll < add_w + (100 - add_w) / 2) k = KIND_REMOVE;
    else if (roll < 80 + add_w / 5)            k = KIND_LOOKUP;
    else                                       k = KIND_DEPART;
    roll = $urandom_range(0, 99);
    if (k != KIND_ADD && queued_len > 0 && roll < 50)
      id = queued_model[$urandom_range(0, queued_len - 1)];
    else if (roll < 70) id = ENTRY_ID_W'($urandom_range(1, 24));
    else if (roll < 76) id = '0;
    else                id = ENTRY_ID_W'($urandom);
    req = make_request(k, id, class_model, $urandom_range(0, 99) < 40);
    if (k != KIND_ADD || $urandom_range(0, 9) == 0)
      req.entry_class = 1'($urandom_range(0, 1));
    return req;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d, cycle %0d)",
             what, got, want, results_checked, cycle_count);
    mismatch_count++;
  endtask

  // Enters and leaves at a rising edge; valid is left high for the caller.
  task automatic send_request(in_item_t req);
    out_item_t res;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    res = queue_step_result(req);
    pending_results.push_back(res);
    requests_sent++;
    if (res.status == STATUS_FAIL) requests_failed++;
    if (res.total_count == CAPACITY) full_hits++;
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_accepted_class(logic value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    class_model = value;
    class_writes++;
  endtask

  // Result checker: a result is taken at the edge after this falling edge
  initial begin
    out_item_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", int'(out_data_o), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.found !== want.found)
            report_mismatch("found", out_data_o.found, want.found);
          if (out_data_o.total_count !== want.total_count)
            report_mismatch("total_count", out_data_o.total_count, want.total_count);
          if (out_data_o.urgent_count !== want.urgent_count)
            report_mismatch("urgent_count", out_data_o.urgent_count, want.urgent_count);
        end
        results_checked++;
      end
    end
  end

  // Receiver backpressure: each stretch picks free-running, light, half or heavy stall
  initial begin
    int mode;
    int run;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 60);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic test_empty_queue();
    send_request(make_request(KIND_DEPART, 12'd0, 1'b0, 1'b0));
    send_request(make_request(KIND_REMOVE, 12'd5, 1'b0, 1'b0));
    send_request(make_request(KIND_LOOKUP, 12'd0, 1'b0, 1'b0));
    send_request(make_request(KIND_LOOKUP, 12'hFFF, 1'b1, 1'b1));
  endtask

  task automatic test_basic_ops();
    send_request(make_request(KIND_ADD, 12'hFFF, 1'b0, 1'b1));
    send_request(make_request(KIND_ADD, 12'd1, 1'b0, 1'b0));
    send_request(make_request(KIND_ADD, 12'd2, 1'b0, 1'b1));
    // refused adds: zero id, wrong class, duplicate
    send_request(make_request(KIND_ADD, 12'd0, 1'b0, 1'b0));
    send_request(make_request(KIND_ADD, 12'd7, 1'b1, 1'b0));
    send_request(make_request(KIND_ADD, 12'hFFF, 1'b0, 1'b0));
    // class and urgent bits must not matter outside of add
    send_request(make_request(KIND_LOOKUP, 12'd1, 1'b1, 1'b1));
    send_request(make_request(KIND_LOOKUP, 12'd3, 1'b0, 1'b0));
    send_request(make_request(KIND_REMOVE, 12'd0, 1'b0, 1'b0));
    send_request(make_request(KIND_REMOVE, 12'd77, 1'b0, 1'b0));
    send_request(make_request(KIND_REMOVE, 12'hFFF, 1'b1, 1'b1));
    send_request(make_request(KIND_DEPART, 12'hABC, 1'b1, 1'b0));
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < CAPACITY - 1; i++) begin
      send_request(make_request(KIND_ADD, ENTRY_ID_W'(12'hA50 + i * 12'h0C3), 1'b0,
                                i[0]));
    end
    send_request(make_request(KIND_ADD, 12'h555, 1'b0, 1'b1));
    send_request(make_request(KIND_DEPART, 12'd0, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int burst;
    int gap;
    int i;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (i = 0; i < burst && sent < n_items; i++) begin
        send_request(random_request());
        sent++;
      end
      if (gap != 0) pause_sender(gap);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_accepted_class(1'b0);
    test_empty_queue();
    test_basic_ops();
    test_full_queue();
    write_accepted_class(1'b1);
    test_random_traffic(350);
    write_accepted_class(1'b0);
    test_random_traffic(350);
    write_accepted_class(1'b1);
    test_random_traffic(350);
    write_accepted_class(1'b0);
    test_random_traffic(350);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("Sent %0d requests (%0d refused), checked %0d results", requests_sent,
             requests_failed, results_checked);
    $display("Queue ran full %0d times; class register written %0d times",
             full_hits, class_writes);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> two_class_priority_queue.f
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_cell.sv
hw/rtl/two_class_priority_queue.sv
hw/rtl/tcpq_checker.sv
tb/two_class_priority_queue_test.sv
